FILE: rtl/bpct_pkg.sv
// Shared types and widths for the circle pair collision time pipeline.
package bpct_pkg;

  localparam int DiffW    = 33;
  localparam int RsW      = 32;
  localparam int CoefW    = 68;
  localparam int ProdW    = 136;
  localparam int DigitW   = 17;
  localparam int NumDigit = 4;
  localparam int RootW    = 68;
  localparam int SqRemW   = 70;
  localparam int NumW     = 70;
  localparam int DenW     = 67;
  localparam int DivW     = 100;
  localparam int QuoW     = 32;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dvx;
    logic signed [DiffW-1:0] dvy;
    logic [RsW-1:0]          rs;
    logic                    still;
  } item_t;

  typedef struct packed {
    logic                    valid;
    logic                    still;
    logic signed [CoefW-1:0] b;
    logic [CoefW-1:0]        a;
    logic [CoefW-1:0]        bm;
    logic [CoefW-1:0]        cm;
    logic                    cneg;
    logic [ProdW-1:0]        bb;
    logic [ProdW-1:0]        ac;
  } mul_t;

  typedef struct packed {
    logic                    valid;
    logic                    nohit;
    logic signed [CoefW-1:0] b;
    logic [CoefW-1:0]        a;
    logic [ProdW-1:0]        d;
    logic [SqRemW-1:0]       r;
    logic [RootW-1:0]        q;
  } sq_t;

  typedef struct packed {
    logic             valid;
    logic             nohit;
    logic             sat;
    logic [DenW-1:0]  den;
    logic [DivW-1:0]  rem;
    logic [QuoW-1:0]  quo;
  } div_t;

endpackage

FILE: rtl/bpct_front.sv
// Input stage: registers a beat, forms the relative motion and flags equal velocities.
module bpct_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    first_x_i,
  input  logic signed [31:0]    first_y_i,
  input  logic signed [31:0]    first_vx_i,
  input  logic signed [31:0]    first_vy_i,
  input  logic [30:0]           first_radius_i,
  input  logic signed [31:0]    second_x_i,
  input  logic signed [31:0]    second_y_i,
  input  logic signed [31:0]    second_vx_i,
  input  logic signed [31:0]    second_vy_i,
  input  logic [30:0]           second_radius_i,
  output logic                  push_valid_o,
  input  logic                  push_stall_i,
  output bpct_pkg::item_t       push_item_o
);

  logic            valid_q, valid_d;
  bpct_pkg::item_t item_q, item_d;
  logic            load;

  assign in_stall_o = valid_q && push_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.dx    = {second_x_i[31], second_x_i} - {first_x_i[31], first_x_i};
    item_d.dy    = {second_y_i[31], second_y_i} - {first_y_i[31], first_y_i};
    item_d.dvx   = {second_vx_i[31], second_vx_i} - {first_vx_i[31], first_vx_i};
    item_d.dvy   = {second_vy_i[31], second_vy_i} - {first_vy_i[31], first_vy_i};
    item_d.rs    = {1'b0, first_radius_i} + {1'b0, second_radius_i};
    item_d.still = (second_vx_i == first_vx_i) && (second_vy_i == first_vy_i);
    if (load) begin
      valid_d = 1'b1;
    end else if (!push_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

FILE: rtl/bpct_queue.sv
// Short FIFO between the input stage and the arithmetic pipeline.
module bpct_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_stall_o,
  input  bpct_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_stall_i,
  output bpct_pkg::item_t pop_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bpct_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_stall_o = (cnt_q == CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/bpct_back.sv
// Arithmetic pipeline: coefficients, discriminant, square root and quotient.
module bpct_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bpct_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            hit_o,
  output logic [31:0]     time_to_hit_o
);

  localparam int CW = bpct_pkg::CoefW;
  localparam int PW = bpct_pkg::ProdW;
  localparam int DG = bpct_pkg::DigitW;
  localparam int ND = bpct_pkg::NumDigit;
  localparam int RW = bpct_pkg::RootW;
  localparam int SW = bpct_pkg::SqRemW;
  localparam int DW = bpct_pkg::DivW;
  localparam int QW = bpct_pkg::QuoW;
  localparam int EW = bpct_pkg::DenW;

  logic adv;
  logic out_valid_q, hit_q;
  logic [QW-1:0] time_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // products
  logic              p0_valid_q, p0_still_q;
  logic signed [65:0] vxx_q, vyy_q, xvx_q, yvy_q, xx_q, yy_q;
  logic [63:0]        rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
    end else if (adv) begin
      p0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_still_q <= in_item_i.still;
      vxx_q      <= in_item_i.dvx * in_item_i.dvx;
      vyy_q      <= in_item_i.dvy * in_item_i.dvy;
      xvx_q      <= in_item_i.dx * in_item_i.dvx;
      yvy_q      <= in_item_i.dy * in_item_i.dvy;
      xx_q       <= in_item_i.dx * in_item_i.dx;
      yy_q       <= in_item_i.dy * in_item_i.dy;
      rr_q       <= in_item_i.rs * in_item_i.rs;
    end
  end

  // coefficients
  bpct_pkg::mul_t ms_q [ND+1];
  bpct_pkg::mul_t m0_d;
  logic [CW-1:0]        a_w, c_w, bsum_w;

  always_comb begin
    a_w    = {3'b0, vxx_q[64:0]} + {3'b0, vyy_q[64:0]};
    bsum_w = {{2{xvx_q[65]}}, xvx_q} + {{2{yvy_q[65]}}, yvy_q};
    c_w    = {3'b0, xx_q[64:0]} + {3'b0, yy_q[64:0]} - {4'b0, rr_q};
    m0_d.valid = p0_valid_q;
    m0_d.still = p0_still_q;
    m0_d.a     = a_w;
    m0_d.b     = {bsum_w[CW-2:0], 1'b0};
    m0_d.bm    = m0_d.b[CW-1] ? CW'(-m0_d.b) : m0_d.b;
    m0_d.cneg  = c_w[CW-1];
    m0_d.cm    = c_w[CW-1] ? -c_w : c_w;
    m0_d.bb    = '0;
    m0_d.ac    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q[0] <= '0;
    end else if (adv) begin
      ms_q[0] <= m0_d;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_mul
    bpct_pkg::mul_t  st_d;
    logic [CW+DG-1:0] pb, pc;
    always_comb begin
      pb    = ms_q[k].bm * ms_q[k].bm[k*DG +: DG];
      pc    = ms_q[k].a * ms_q[k].cm[k*DG +: DG];
      st_d    = ms_q[k];
      st_d.bb = ms_q[k].bb + ({(PW-CW-DG)'(0), pb} << (k * DG));
      st_d.ac = ms_q[k].ac + ({(PW-CW-DG)'(0), pc} << (k * DG));
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ms_q[k+1] <= '0;
      end else if (adv) begin
        ms_q[k+1] <= st_d;
      end
    end
  end

  // discriminant
  bpct_pkg::sq_t sq_q [RW+1];
  bpct_pkg::sq_t sq0_d;
  logic [PW:0]   det_w, ac4_w;

  always_comb begin
    ac4_w = {1'b0, ms_q[ND].ac[PW-3:0], 2'b00};
    det_w = ms_q[ND].cneg ? ({1'b0, ms_q[ND].bb} + ac4_w) : ({1'b0, ms_q[ND].bb} - ac4_w);
    sq0_d.valid = ms_q[ND].valid;
    sq0_d.nohit = ms_q[ND].still || det_w[PW];
    sq0_d.b     = ms_q[ND].b;
    sq0_d.a     = ms_q[ND].a;
    sq0_d.d     = det_w[PW-1:0];
    sq0_d.r     = '0;
    sq0_d.q     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (adv) begin
      sq_q[0] <= sq0_d;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    bpct_pkg::sq_t st_d;
    logic [SW-1:0] rr, tt;
    always_comb begin
      rr   = {sq_q[k].r[SW-3:0], sq_q[k].d[2*(RW-1-k) +: 2]};
      tt   = {sq_q[k].q, 2'b01};
      st_d = sq_q[k];
      if (rr >= tt) begin
        st_d.r = rr - tt;
        st_d.q = {sq_q[k].q[RW-2:0], 1'b1};
      end else begin
        st_d.r = rr;
        st_d.q = {sq_q[k].q[RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (adv) begin
        sq_q[k+1] <= st_d;
      end
    end
  end

  // numerator, saturation test, quotient
  bpct_pkg::div_t dv_q [QW+1];
  bpct_pkg::div_t dv0_d;
  logic [bpct_pkg::NumW-1:0] num_w;

  always_comb begin
    num_w = '0 - {{2{sq_q[RW].b[CW-1]}}, sq_q[RW].b} - {2'b0, sq_q[RW].q};
    dv0_d.valid = sq_q[RW].valid;
    dv0_d.nohit = sq_q[RW].nohit || num_w[bpct_pkg::NumW-1];
    dv0_d.den   = {sq_q[RW].a[EW-2:0], 1'b0};
    dv0_d.rem   = {17'b0, num_w[EW-1:0], 16'b0};
    dv0_d.sat   = dv0_d.rem >= {1'b0, dv0_d.den, 32'b0};
    dv0_d.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (adv) begin
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    bpct_pkg::div_t st_d;
    logic [DW-1:0]  tt;
    always_comb begin
      tt   = {(DW-EW)'(0), dv_q[j].den} << (QW - 1 - j);
      st_d = dv_q[j];
      if (dv_q[j].rem >= tt) begin
        st_d.rem            = dv_q[j].rem - tt;
        st_d.quo[QW-1-j]    = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= '0;
      end else if (adv) begin
        dv_q[j+1] <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      time_q      <= '0;
    end else if (adv) begin
      out_valid_q <= dv_q[QW].valid;
      hit_q       <= !dv_q[QW].nohit;
      time_q      <= dv_q[QW].nohit ? '0 : (dv_q[QW].sat ? '1 : dv_q[QW].quo);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign time_to_hit_o = time_q;

endmodule

FILE: rtl/ball_pair_collision_time.sv
// Throughput: one beat per cycle; the pipeline advances as one unit and holds while the
// output beat is stalled, with the input register and queue absorbing QUEUE_DEPTH + 1 beats.
// The pipeline length is dominated by the 68 square-root stages and the 32 quotient stages.
// Reset: asynchronous, active low; clears all valid flags and queue pointers.
// Top level of the circle pair collision time unit.
module ball_pair_collision_time #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] first_vx_i,
  input  logic signed [31:0] first_vy_i,
  input  logic [30:0]        first_radius_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic signed [31:0] second_vx_i,
  input  logic signed [31:0] second_vy_i,
  input  logic [30:0]        second_radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [31:0]        time_to_hit_o
);

  logic            push_valid, push_stall, pop_valid, pop_stall;
  bpct_pkg::item_t push_item, pop_item;

  bpct_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .first_x_i,
    .first_y_i,
    .first_vx_i,
    .first_vy_i,
    .first_radius_i,
    .second_x_i,
    .second_y_i,
    .second_vx_i,
    .second_vy_i,
    .second_radius_i,
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_item_o  (push_item)
  );

  bpct_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_item_o   (pop_item)
  );

  bpct_back u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i    (pop_valid),
    .in_stall_o    (pop_stall),
    .in_item_i     (pop_item),
    .out_valid_o,
    .out_stall_i,
    .hit_o,
    .time_to_hit_o
  );

endmodule
